FILE: rtl/ile_pkg.sv
package ile_pkg;

    localparam int CAPACITY    = 32;
    localparam int VALUE_WIDTH = 32;

    localparam int IDX_W   = $clog2(CAPACITY);
    localparam int CNT_W   = $clog2(CAPACITY + 1);
    localparam int FIELD_W = 6;
    localparam int PW      = (CNT_W > FIELD_W) ? CNT_W : FIELD_W;

    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_GET    = 2'd1;
    localparam logic [1:0] REQ_REMOVE = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    typedef struct packed {
        logic                   ins;
        logic                   rem;
        logic [PW-1:0]          pos;
        logic [VALUE_WIDTH-1:0] value;
    } cell_cmd_t;

    function automatic logic [VALUE_WIDTH-1:0] to_store(input logic [31:0] v);
        logic [VALUE_WIDTH-1:0] r;
        r = '0;
        for (int b = 0; b < VALUE_WIDTH; b++)
        begin
            if (b < 32)
            begin
                r[b] = v[b];
            end
        end
        return r;
    endfunction

    function automatic logic [31:0] to_field(input logic [VALUE_WIDTH-1:0] v);
        logic [31:0] r;
        r = '0;
        for (int b = 0; b < 32; b++)
        begin
            if (b < VALUE_WIDTH)
            begin
                r[b] = v[b];
            end
        end
        return r;
    endfunction

endpackage

FILE: rtl/indexed_list_engine_top.sv
// A request taken at a clock edge is registered there and has its result on the result ports,
// marked by done, during the following cycle.
// Throughput: one request per cycle; busy is tied low, as the affected cells shift together when an edit is taken.
// Reset: rst_n clears the entry count and the result strobe; stored entries keep
// whatever they hold. The receiver cannot stall, so each beat shows for one cycle.
module indexed_list_engine_top
    import ile_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         req_type,
    input  logic [5:0]         position,
    input  logic signed [31:0] write_value,
    output logic               done,
    output logic signed [31:0] read_value,
    output logic [1:0]         status,
    output logic [5:0]         entry_count
);

    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    logic                   accept;
    logic [PW-1:0]          pos_ext;
    logic [PW-1:0]          cnt_ext;
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;
    logic                   ins_ok;
    logic                   rem_ok;
    logic [1:0]             st;
    logic [31:0]            rd;
    cell_cmd_t              cmd;
    logic [VALUE_WIDTH-1:0] cell_value [CAPACITY];

    logic                   done_reg;
    logic [31:0]            read_value_reg;
    logic [1:0]             status_reg;
    logic [5:0]             entry_count_reg;

    assign busy    = 1'b0;
    assign accept  = start && !busy;
    assign pos_ext = PW'(position);
    assign cnt_ext = PW'(count_reg);

    always_comb
    begin
        st     = ST_OK;
        ins_ok = 1'b0;
        rem_ok = 1'b0;
        rd     = '0;
        unique case (req_type)
            REQ_INSERT:
            begin
                if (pos_ext > cnt_ext)
                begin
                    st = ST_RANGE;
                end
                else if (count_reg == CAP_CNT)
                begin
                    st = ST_FULL;
                end
                else
                begin
                    ins_ok = 1'b1;
                end
            end
            REQ_GET:
            begin
                if (pos_ext >= cnt_ext)
                begin
                    st = ST_RANGE;
                end
                else
                begin
                    rd = to_field(cell_value[pos_ext[IDX_W-1:0]]);
                end
            end
            REQ_REMOVE:
            begin
                if (count_reg == '0)
                begin
                    st = ST_EMPTY;
                end
                else if (pos_ext >= cnt_ext)
                begin
                    st = ST_RANGE;
                end
                else
                begin
                    rem_ok = 1'b1;
                end
            end
            default:
            begin
                st = ST_OK;
            end
        endcase
    end

    assign cmd.ins   = accept && ins_ok;
    assign cmd.rem   = accept && rem_ok;
    assign cmd.pos   = pos_ext;
    assign cmd.value = to_store(write_value);

    always_comb
    begin
        count_next = count_reg;
        priority if (cmd.ins)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (cmd.rem)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        logic [VALUE_WIDTH-1:0] left_value;
        logic [VALUE_WIDTH-1:0] right_value;

        if (g == 0)
        begin : g_first
            assign left_value = cmd.value;
        end
        else
        begin : g_inner_l
            assign left_value = cell_value[g-1];
        end

        if (g == CAPACITY - 1)
        begin : g_last
            assign right_value = cell_value[g];
        end
        else
        begin : g_inner_r
            assign right_value = cell_value[g+1];
        end

        ile_cell u_cell
        (
            .clk         (clk),
            .cmd         (cmd),
            .index       (IDX_W'(g)),
            .left_value  (left_value),
            .right_value (right_value),
            .value       (cell_value[g])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            read_value_reg  <= rd;
            status_reg      <= st;
            entry_count_reg <= 6'(count_next);
        end
    end

    assign done        = done_reg;
    assign read_value  = read_value_reg;
    assign status      = status_reg;
    assign entry_count = entry_count_reg;

    a_done_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> done)
        else $error("Accepted request produced no result beat.");

    a_no_spurious_done: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> !done)
        else $error("Result beat without an accepted request.");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP_CNT)
        else $error("Entry count exceeds capacity.");

    a_full_means_capacity: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == ST_FULL)) |-> (entry_count == 6'(CAP_CNT)))
        else $error("Full status reported below capacity.");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.ins || cmd.rem) |=> (count_reg != $past(count_reg)))
        else $error("List edit did not change the entry count.");

endmodule

FILE: rtl/ile_cell.sv
module ile_cell
    import ile_pkg::*;
(
    input  logic                   clk,
    input  cell_cmd_t              cmd,
    input  logic [IDX_W-1:0]       index,
    input  logic [VALUE_WIDTH-1:0] left_value,
    input  logic [VALUE_WIDTH-1:0] right_value,
    output logic [VALUE_WIDTH-1:0] value
);

    logic [VALUE_WIDTH-1:0] value_reg;
    logic [VALUE_WIDTH-1:0] value_next;
    logic [PW-1:0]          idx_ext;

    assign idx_ext = PW'(index);

    // Insert pulls from the lower neighbor, remove from the upper neighbor.
    always_comb
    begin
        value_next = value_reg;
        priority if (cmd.ins && (idx_ext > cmd.pos))
        begin
            value_next = left_value;
        end
        else if (cmd.ins && (idx_ext == cmd.pos))
        begin
            value_next = cmd.value;
        end
        else if (cmd.rem && (idx_ext >= cmd.pos))
        begin
            value_next = right_value;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule
